/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the frame store pixel access unit.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // frame store size and coordinate limit
    localparam int          MEM_BYTES = 1048576;
    localparam int          ADDR_W    = $clog2(MEM_BYTES);
    localparam logic [15:0] COORD_MAX = 16'd4095;

    // fixed field widths
    localparam int BPP_W    = 6;
    localparam int PITCH_W  = 16;
    localparam int BASE_W   = 20;
    localparam int COORD_W  = 12;
    localparam int COLOR_W  = 32;
    localparam int CFG_W    = 20;
    localparam int CFG_IX_W = 2;

    // address arithmetic widths
    localparam int ROW_W  = COORD_W + PITCH_W;
    localparam int XOFF_W = COORD_W + 2;
    localparam int SUM_W  = ROW_W + 2;

    // register indexes
    localparam logic [CFG_IX_W-1:0] REG_BPP   = 2'd0;
    localparam logic [CFG_IX_W-1:0] REG_PITCH = 2'd1;
    localparam logic [CFG_IX_W-1:0] REG_BASE  = 2'd2;

    localparam logic [BPP_W-1:0] BPP_RESET = 6'd32;
    localparam logic [BPP_W-1:0] BPP_ONE   = 6'd1;

    // command from controller to datapath
    typedef struct packed {
        logic load_req;
        logic calc_mul;
        logic calc_sum;
        logic calc_chk;
        logic cnt_inc;
        logic mem_rd;
        logic mem_wr;
        logic wr_bit;
        logic out_load;
    } fpa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic write;
        logic unsup;
        logic one_bit;
        logic oor;
        logic last;
        logic out_busy;
    } fpa_stat_t;

    // bytes per pixel for byte-aligned depths, 0 otherwise
    function automatic logic [2:0] depth_bytes(input logic [BPP_W-1:0] bpp);
        logic [2:0] n;
        case (bpp)
            6'd8:    n = 3'd1;
            6'd16:   n = 3'd2;
            6'd24:   n = 3'd3;
            6'd32:   n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

/* rtl/framebuffer_pixel_access.sv */
// ----------------------------------------------------------------------------
// framebuffer_pixel_access
// Pixel read/write unit over a byte-addressed little-endian frame store.
// ----------------------------------------------------------------------------
// One request is in flight at a time. After a request beat is taken the
// unit works out the address (row multiply, sum, range check), then moves
// the pixel through the single byte-wide port of the frame store one byte
// per cycle, then, once the previous result has been taken, hands the
// result to the output register and is ready again in the next cycle. A
// depth-one write reads, modifies and writes back its byte; an unsupported
// depth or out-of-range access goes straight to the hand-off. The next
// request is taken while a result still waits on m_ready. The store has
// no reset; a byte must be written before read.
// Config writes are taken at any time and must only be issued while idle.
module framebuffer_pixel_access
    import fpa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_IX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [COORD_W-1:0]  s_pos_x,
    input  logic [COORD_W-1:0]  s_pos_y,
    input  logic [COLOR_W-1:0]  s_color_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COLOR_W-1:0]  m_pixel_out,
    output logic [BASE_W-1:0]   m_byte_address,
    output logic                m_address_valid,
    output logic                m_out_of_range
);

    fpa_cmd_t  cmd;
    fpa_stat_t stat;

    fpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fpa_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_req_type      (s_req_type),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_color_in      (s_color_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_byte_address  (m_byte_address),
        .m_address_valid (m_address_valid),
        .m_out_of_range  (m_out_of_range),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

/* rtl/fpa_ram.sv */
// ----------------------------------------------------------------------------
// fpa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fpa_ctrl.sv */
// ----------------------------------------------------------------------------
// fpa_ctrl
// Sequencer for one pixel access: address calculation, byte-serial
// memory traffic and hand-off to the result register.
// ----------------------------------------------------------------------------
module fpa_ctrl
    import fpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  fpa_stat_t stat,
    output fpa_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_MUL     = 9'b000000010,
        ST_SUM     = 9'b000000100,
        ST_CHECK   = 9'b000001000,
        ST_RD      = 9'b000010000,
        ST_RD_LAST = 9'b000100000,
        ST_WR      = 9'b001000000,
        ST_SET_BIT = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.calc_mul = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM: begin
                cmd.calc_sum = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.calc_chk = 1'b1;
                if (stat.unsup || stat.oor) begin
                    state_next = ST_DONE;
                end else if (stat.write && !stat.one_bit) begin
                    state_next = ST_WR;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.mem_rd = 1'b1;
                if (stat.last) begin
                    state_next = ST_RD_LAST;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_RD_LAST: begin
                // last read beat lands in the accumulator here
                if (stat.one_bit && stat.write) begin
                    state_next = ST_SET_BIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WR: begin
                cmd.mem_wr = 1'b1;
                if (stat.last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_SET_BIT: begin
                cmd.mem_wr = 1'b1;
                cmd.wr_bit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_rd_last_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_LAST) |-> $past(state_reg == ST_RD))
        else $error("read drain without a preceding read");
`endif

endmodule

/* rtl/fpa_datapath.sv */
// ----------------------------------------------------------------------------
// fpa_datapath
// Config registers, address arithmetic, byte-wide frame store and the
// result register.
// ----------------------------------------------------------------------------
module fpa_datapath
    import fpa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_IX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                s_req_type,
    input  logic [COORD_W-1:0]  s_pos_x,
    input  logic [COORD_W-1:0]  s_pos_y,
    input  logic [COLOR_W-1:0]  s_color_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COLOR_W-1:0]  m_pixel_out,
    output logic [BASE_W-1:0]   m_byte_address,
    output logic                m_address_valid,
    output logic                m_out_of_range,
    input  fpa_cmd_t            cmd,
    output fpa_stat_t           stat
);

    logic [BPP_W-1:0]   bpp_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [BASE_W-1:0]  base_reg;

    logic               type_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [COLOR_W-1:0] color_reg;

    logic [ROW_W-1:0]   row_reg;
    logic [XOFF_W-1:0]  xoff_reg;
    logic [SUM_W-1:0]   addr_reg;
    logic               oor_reg;
    logic [1:0]         cnt_reg;
    logic [COLOR_W-1:0] acc_reg;
    logic               cap_vld_reg;
    logic [1:0]         cap_idx_reg;

    logic               m_valid_reg;
    logic [COLOR_W-1:0] pix_out_reg;
    logic [BASE_W-1:0]  addr_out_reg;
    logic               avalid_out_reg;
    logic               oor_out_reg;

    logic [2:0]         nbytes;
    logic               one_bit;
    logic               unsup;
    logic [1:0]         span_m1;
    logic [XOFF_W-1:0]  xoff_next;
    logic [SUM_W:0]     end_addr;
    logic               oor_now;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_rdata;
    logic [7:0]         set_byte;
    logic [2:0]         bit_pos;
    logic [COLOR_W-1:0] pix_next;

    assign nbytes  = depth_bytes(bpp_reg);
    assign one_bit = (bpp_reg == BPP_ONE);
    assign unsup   = (nbytes == 3'd0) && !one_bit;
    assign span_m1 = one_bit ? 2'd0 : 2'(nbytes - 3'd1);
    assign bit_pos = ~x_reg[2:0];

    always_comb begin
        case (nbytes)
            3'd1:    xoff_next = XOFF_W'(x_reg);
            3'd2:    xoff_next = XOFF_W'({x_reg, 1'b0});
            3'd3:    xoff_next = XOFF_W'(x_reg) + XOFF_W'({x_reg, 1'b0});
            3'd4:    xoff_next = XOFF_W'({x_reg, 2'b00});
            default: xoff_next = XOFF_W'(x_reg[COORD_W-1:3]);
        endcase
    end

    // last byte of the pixel must stay inside the store
    assign end_addr = (SUM_W+1)'(addr_reg) + (SUM_W+1)'(span_m1) + (SUM_W+1)'(1);
    assign oor_now  = (16'(x_reg) > COORD_MAX) || (16'(y_reg) > COORD_MAX) ||
                      (end_addr > (SUM_W+1)'(MEM_BYTES));

    assign mem_addr = addr_reg[ADDR_W-1:0] + ADDR_W'(cnt_reg);

    always_comb begin
        set_byte          = acc_reg[7:0];
        set_byte[bit_pos] = color_reg[0];
    end

    assign mem_wdata = cmd.wr_bit ? set_byte : color_reg[8*cnt_reg +: 8];

    always_comb begin
        if (type_reg || oor_reg || unsup) begin
            pix_next = '0;
        end else if (one_bit) begin
            pix_next = COLOR_W'(acc_reg[bit_pos]);
        end else begin
            pix_next = acc_reg;
        end
    end

    fpa_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.mem_wr),
        .re    (cmd.mem_rd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg     <= BPP_RESET;
            pitch_reg   <= '0;
            base_reg    <= '0;
            cap_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BPP:   bpp_reg   <= cfg_wr_data[BPP_W-1:0];
                    REG_PITCH: pitch_reg <= cfg_wr_data[PITCH_W-1:0];
                    REG_BASE:  base_reg  <= cfg_wr_data[BASE_W-1:0];
                    default:   ;
                endcase
            end
            cap_vld_reg <= cmd.mem_rd;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            type_reg  <= s_req_type;
            x_reg     <= s_pos_x;
            y_reg     <= s_pos_y;
            color_reg <= s_color_in;
        end
        if (cmd.calc_mul) begin
            row_reg  <= ROW_W'(y_reg) * ROW_W'(pitch_reg);
            xoff_reg <= xoff_next;
        end
        if (cmd.calc_sum) begin
            addr_reg <= SUM_W'(base_reg) + SUM_W'(row_reg) + SUM_W'(xoff_reg);
        end
        if (cmd.calc_chk) begin
            oor_reg <= oor_now;
        end
        if (cmd.load_req) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        cap_idx_reg <= cnt_reg;
        if (cmd.load_req) begin
            acc_reg <= '0;
        end else if (cap_vld_reg) begin
            acc_reg[8*cap_idx_reg +: 8] <= mem_rdata;
        end
        if (cmd.out_load) begin
            pix_out_reg    <= pix_next;
            addr_out_reg   <= (!unsup && !one_bit && !oor_reg) ? addr_reg[BASE_W-1:0] : '0;
            avalid_out_reg <= !unsup && !one_bit;
            oor_out_reg    <= oor_reg && !unsup;
        end
    end

    assign stat.write    = type_reg;
    assign stat.unsup    = unsup;
    assign stat.one_bit  = one_bit;
    assign stat.oor      = oor_now;
    assign stat.last     = (cnt_reg == span_m1);
    assign stat.out_busy = m_valid_reg && !m_ready;

    assign m_valid         = m_valid_reg;
    assign m_pixel_out     = pix_out_reg;
    assign m_byte_address  = addr_out_reg;
    assign m_address_valid = avalid_out_reg;
    assign m_out_of_range  = oor_out_reg;

`ifndef SYNTHESIS
    a_no_write_when_oor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> (!oor_reg && !unsup))
        else $error("store written for a suppressed access");

    a_write_only_for_write_req: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> type_reg)
        else $error("store written during a read request");

    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result register overwritten before its beat was taken");
`endif

endmodule
